>>> rtl/sacl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacl_pkg
// shared types, constants and helpers for the lru cache simulator
// ---------------------------------------------------------------------------
package sacl_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int TAG_WIDTH    = 32;

    localparam int SET_COUNT = 1 << MAX_SET_BITS;
    localparam int SET_W     = MAX_SET_BITS;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
    localparam int SEL_W     = $clog2(MAX_SET_BITS + 1);
    localparam int SHIFT_W   = $clog2(31 + MAX_SET_BITS + 1);
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 5;

    typedef enum logic [1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_OTHER  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_MISS  = 2'd1,
        OUT_EVICT = 2'd2,
        OUT_NONE  = 2'd3
    } outcome_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        mode_t        mode;
        logic [63:0]  address;
    } cache_req_t;

    typedef struct packed {
        outcome_t     outcome;
        logic         extra_hit;
        logic [5:0]   set_index;
        logic [2:0]   way_used;
        logic [31:0]  hit_total;
        logic [31:0]  miss_total;
        logic [31:0]  eviction_total;
    } cache_rsp_t;

    // stamp of zero marks an empty line
    typedef struct packed {
        logic [TAG_WIDTH-1:0] tag;
        logic [STAMP_W-1:0]   stamp;
    } line_t;

    typedef line_t [MAX_WAYS-1:0] row_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             evict;
    } lookup_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == '1) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

>>> rtl/sacl_set_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacl_set_store
// one row per set holding all ways; registered read, row valid flops
// ---------------------------------------------------------------------------
module sacl_set_store
    import sacl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_set,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_set,
    input  row_t             wr_row,
    output row_t             rd_row
);

    row_t                 row_mem [SET_COUNT];
    row_t                 rd_data_reg;
    logic                 rd_valid_reg;
    logic [SET_COUNT-1:0] row_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_set] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_set];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_set] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_set];
            end
        end
    end

    // never-written row reads as empty lines
    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/sacl_way_match.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sacl_way_match
// parallel tag compare and oldest-stamp victim tree over one set
// ---------------------------------------------------------------------------
module sacl_way_match
    import sacl_pkg::*;
(
    input  row_t                 row,
    input  logic [TAG_WIDTH-1:0] tag,
    input  logic [WAY_CNT_W-1:0] ways,
    output lookup_t              result
);

    localparam int LEVELS = $clog2(MAX_WAYS);
    localparam int PAD    = 1 << LEVELS;

    logic [STAMP_W:0] key [LEVELS+1][PAD];
    logic [WAY_W-1:0] idx [LEVELS+1][PAD];
    logic             hit;
    logic [WAY_W-1:0] hit_way;

    // lowest matching way wins
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if ((WAY_CNT_W'(i) < ways) && (row[i].stamp != '0) && (row[i].tag == tag))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
        end
    end

    // unused ways get the top key bit so they never win; ties keep lower way
    always_comb
    begin
        for (int n = 0; n < PAD; n++)
        begin
            idx[0][n] = WAY_W'(n);
            if ((n < MAX_WAYS) && (WAY_CNT_W'(n) < ways))
            begin
                key[0][n] = {1'b0, row[n].stamp};
            end
            else
            begin
                key[0][n] = {1'b1, {STAMP_W{1'b0}}};
            end
        end
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            for (int n = 0; n < PAD; n++)
            begin
                key[lvl+1][n] = '0;
                idx[lvl+1][n] = '0;
            end
            for (int n = 0; n < PAD / 2; n++)
            begin
                if (key[lvl][2*n+1] < key[lvl][2*n])
                begin
                    key[lvl+1][n] = key[lvl][2*n+1];
                    idx[lvl+1][n] = idx[lvl][2*n+1];
                end
                else
                begin
                    key[lvl+1][n] = key[lvl][2*n];
                    idx[lvl+1][n] = idx[lvl][2*n];
                end
            end
        end
    end

    assign result.hit   = hit;
    assign result.way   = hit ? hit_way : idx[LEVELS][0];
    assign result.evict = !hit && (key[LEVELS][0][STAMP_W-1:0] != '0);

endmodule

>>> rtl/set_assoc_cache_lru_sim.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// set-associative lru cache model with hit, miss and eviction counting
// ---------------------------------------------------------------------------
// result: strobe registered from the lookup state through the done register,
// one cycle wide
// items: a new item is taken only in idle, after the read then write of the set row
// the receiver cannot stall; busy is high only in the lookup cycle
// reset: counters and config to defaults, set rows marked empty at once by
// row valid flops, no clearing pass
module set_assoc_cache_lru_sim
    import sacl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cache_req_t       req,
    output logic             done,
    output cache_rsp_t       rsp,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // configuration
    logic [2:0]           set_bits_reg;
    logic [4:0]           block_bits_reg;
    logic [3:0]           ways_reg;
    logic [SEL_W-1:0]     set_eff;
    logic [WAY_CNT_W-1:0] ways_eff;

    // control and item registers
    state_t               state_reg, state_next;
    mode_t                mode_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [SET_W-1:0]     set_reg;
    logic [STAMP_W-1:0]   time_reg;
    logic [CNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]     miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]     evict_cnt_reg, evict_cnt_next;
    logic                 done_reg;
    cache_rsp_t           rsp_reg, rsp_next;

    // datapath
    logic                 accept;
    logic                 in_lookup;
    logic [SHIFT_W-1:0]   tag_shift;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     set_in;
    logic [TAG_WIDTH-1:0] tag_in;
    row_t                 rd_row;
    row_t                 wr_row;
    logic                 wr_en;
    lookup_t              look;
    logic                 access;
    logic [1:0]           hit_inc;
    logic [CNT_W:0]       hit_sum;

    assign accept    = start && !busy;
    assign in_lookup = (state_reg == ST_LOOKUP);
    assign busy      = in_lookup;

    // config write port, index beyond the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 3'd1;
            block_bits_reg <= 5'd1;
            ways_reg       <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[4:0];
                CFG_WAYS:       ways_reg       <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // clamp set bits to the table size, ways to 1..MAX_WAYS
    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
        begin
            set_eff = SEL_W'(MAX_SET_BITS);
        end
        else
        begin
            set_eff = SEL_W'(set_bits_reg);
        end
        if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WAY_CNT_W'(MAX_WAYS);
        end
        else if (ways_reg == 4'd0)
        begin
            ways_eff = WAY_CNT_W'(1);
        end
        else
        begin
            ways_eff = WAY_CNT_W'(ways_reg);
        end
    end

    // address split: offset | set | tag
    assign tag_shift = SHIFT_W'(block_bits_reg) + SHIFT_W'(set_eff);
    assign set_mask  = ~({SET_W{1'b1}} << set_eff);
    assign set_in    = SET_W'(req.address >> block_bits_reg) & set_mask;
    assign tag_in    = TAG_WIDTH'(req.address >> tag_shift);

    // set row is read on the accepting edge, ready in the lookup cycle
    sacl_set_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_set (set_in),
        .wr_en  (wr_en),
        .wr_set (set_reg),
        .wr_row (wr_row),
        .rd_row (rd_row)
    );

    sacl_way_match u_match (
        .row    (rd_row),
        .tag    (tag_reg),
        .ways   (ways_eff),
        .result (look)
    );

    // write back in the lookup cycle; the next read is only accepted after it, in
    // idle, so no forwarding is needed
    assign access = (mode_reg != MODE_OTHER);
    assign wr_en  = in_lookup && access;

    always_comb
    begin
        wr_row                 = rd_row;
        wr_row[look.way].stamp = time_reg;
        if (!look.hit)
        begin
            wr_row[look.way].tag = tag_reg;
        end
    end

    // counters: a modify adds one guaranteed hit on top of its access
    assign hit_inc = {1'b0, access && look.hit} + {1'b0, mode_reg == MODE_MODIFY};
    assign hit_sum = {1'b0, hit_cnt_reg} + (CNT_W+1)'(hit_inc);

    always_comb
    begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        if (in_lookup)
        begin
            hit_cnt_next = hit_sum[CNT_W] ? {CNT_W{1'b1}} : hit_sum[CNT_W-1:0];
            if (access && !look.hit)
            begin
                miss_cnt_next = sat_inc(miss_cnt_reg);
                if (look.evict)
                begin
                    evict_cnt_next = sat_inc(evict_cnt_reg);
                end
            end
        end
    end

    // result item
    always_comb
    begin
        rsp_next                = rsp_reg;
        rsp_next.hit_total      = hit_cnt_next;
        rsp_next.miss_total     = miss_cnt_next;
        rsp_next.eviction_total = evict_cnt_next;
        if (access)
        begin
            rsp_next.extra_hit = (mode_reg == MODE_MODIFY);
            rsp_next.set_index = 6'(set_reg);
            rsp_next.way_used  = 3'(look.way);
            if (look.hit)
            begin
                rsp_next.outcome = OUT_HIT;
            end
            else if (look.evict)
            begin
                rsp_next.outcome = OUT_EVICT;
            end
            else
            begin
                rsp_next.outcome = OUT_MISS;
            end
        end
        else
        begin
            rsp_next.outcome   = OUT_NONE;
            rsp_next.extra_hit = 1'b0;
            rsp_next.set_index = '0;
            rsp_next.way_used  = '0;
        end
    end

    // control fsm
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = accept ? ST_LOOKUP : ST_IDLE;
            ST_LOOKUP: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
            done_reg      <= in_lookup;
            // every item advances time, saturating
            if (accept)
            begin
                time_reg <= sat_inc(time_reg);
            end
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            tag_reg  <= tag_in;
            set_reg  <= set_in;
        end
        if (in_lookup)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // checks
    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_LOOKUP))
        else $error("result strobe without a lookup cycle");

    a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |=> (state_reg == ST_IDLE))
        else $error("lookup lasted more than one cycle");

    a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
        evict_cnt_reg <= miss_cnt_reg)
        else $error("eviction count exceeds miss count");

    a_time_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.outcome != OUT_NONE) |-> (time_reg != '0))
        else $error("line stamped with an empty-line time");

endmodule
